/* hdl/lis_pkg.sv */
// Shared types, constants and control structs for the increasing subsequence core.
package lis_pkg;

  localparam int unsigned MaxItemsDef = 64;
  localparam int unsigned ValW        = 31;
  localparam int unsigned PosW        = 6;
  localparam int unsigned LenW        = 7;

  typedef logic signed [ValW-1:0] value_t;

  // Largest magnitude kept, and the minus-infinity marker for a chain start.
  localparam value_t ValMax = {1'b0, {(ValW-1){1'b1}}};
  localparam value_t NegSat = {1'b1, {(ValW-2){1'b0}}, 1'b1};
  localparam value_t NegInf = {1'b1, {(ValW-1){1'b0}}};

  typedef struct packed {
    logic signed [ValW-1:0] value;
    logic                   last;
  } in_item_t;

  typedef struct packed {
    logic signed [ValW-1:0] element;
    logic [PosW-1:0]        position;
    logic [LenW-1:0]        length;
    logic                   final_res;
  } out_item_t;

  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StSearch = 7'b0000010,
    StInsert = 7'b0000100,
    StTail   = 7'b0001000,
    StInit   = 7'b0010000,
    StWalk   = 7'b0100000,
    StClear  = 7'b1000000
  } state_e;

  typedef struct packed {
    logic load;
    logic search;
    logic insert;
    logic tail_fetch;
    logic walk_init;
    logic walk;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic in_last;
    logic store_full;
    logic search_done;
    logic run_last;
    logic empty;
    logic walk_done;
    logic out_stall;
  } status_t;

endpackage

/* hdl/lis_datapath.sv */
// Datapath: tail table search, item and predecessor stores, backward walk and output register.
module lis_datapath #(
  parameter int unsigned MaxItems = lis_pkg::MaxItemsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lis_pkg::in_item_t  in_item_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output lis_pkg::out_item_t out_item_o,
  input  lis_pkg::cmd_t      cmd_i,
  output lis_pkg::status_t   status_o
);
  import lis_pkg::*;

  localparam int unsigned IdxW = (MaxItems > 1) ? $clog2(MaxItems) : 1;
  localparam int unsigned CntW = $clog2(MaxItems + 1);

  // Memories
  value_t tail_mem [MaxItems];
  value_t item_mem [MaxItems];
  value_t pred_mem [MaxItems];
  value_t tail_rd_q, item_rd_q, pred_rd_q;

  // Run state
  logic [CntW-1:0] len_q, len_d, cnt_q, cnt_d;
  value_t          val_q, want_q;
  logic            last_q;
  logic [CntW-1:0] lo_q, hi_q;
  logic [IdxW-1:0] i_q, j_q;

  logic               out_valid_q;
  out_item_t          out_q;

  value_t          in_val_sat, pred_val;
  logic [CntW:0]   mid_sum, nxt_sum;
  logic [CntW-1:0] mid_c, lo_n, hi_n;
  logic            less, search_done, match, walk_done;
  logic            tail_re, item_re, emit;
  logic [IdxW-1:0] tail_raddr, item_raddr;

  assign in_val_sat = (in_item_i.value == NegInf) ? NegSat : in_item_i.value;

  // One bisection step of the search over the tail table
  assign mid_sum     = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_c       = mid_sum[CntW:1];
  assign search_done = (lo_q == hi_q);
  assign less        = (tail_rd_q < val_q);
  assign lo_n        = less ? (mid_c + 1'b1) : lo_q;
  assign hi_n        = less ? hi_q : mid_c;
  assign nxt_sum     = {1'b0, lo_n} + {1'b0, hi_n};

  always_comb begin
    tail_raddr = IdxW'(len_q - 1'b1);
    if (cmd_i.load) begin
      tail_raddr = IdxW'(len_q >> 1);
    end else if (cmd_i.search) begin
      // Once the slot is found, fetch the tail just below it
      tail_raddr = search_done ? IdxW'(lo_q - 1'b1) : IdxW'(nxt_sum[CntW:1]);
    end
  end

  assign tail_re  = cmd_i.load | cmd_i.search | cmd_i.tail_fetch;
  assign pred_val = (lo_q == '0) ? NegInf : tail_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.insert) tail_mem[IdxW'(lo_q)] <= val_q;
    if (tail_re) tail_rd_q <= tail_mem[tail_raddr];
  end

  // Backward walk
  assign match     = (item_rd_q == want_q);
  assign walk_done = (match && (j_q == '0)) || (i_q == '0);
  assign emit      = cmd_i.walk && match;
  assign item_re   = cmd_i.walk_init | (cmd_i.walk & ~walk_done);
  assign item_raddr = cmd_i.walk_init ? IdxW'(cnt_q - 1'b1) : (i_q - 1'b1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.insert) begin
      item_mem[IdxW'(cnt_q)] <= val_q;
      pred_mem[IdxW'(cnt_q)] <= pred_val;
    end
    if (item_re) begin
      item_rd_q <= item_mem[item_raddr];
      pred_rd_q <= pred_mem[item_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q  <= in_val_sat;
      last_q <= in_item_i.last;
      lo_q   <= '0;
      hi_q   <= len_q;
    end else if (cmd_i.search && !search_done) begin
      lo_q <= lo_n;
      hi_q <= hi_n;
    end
    if (cmd_i.walk_init) begin
      want_q <= tail_rd_q;
      i_q    <= IdxW'(cnt_q - 1'b1);
      j_q    <= IdxW'(len_q - 1'b1);
    end else if (cmd_i.walk) begin
      if (match) begin
        want_q <= pred_rd_q;
        j_q    <= j_q - 1'b1;
      end
      i_q <= i_q - 1'b1;
    end
  end

  // Fill counts: entries at or above len_q read as plus infinity and never steer the search
  always_comb begin
    len_d = len_q;
    cnt_d = cnt_q;
    if (cmd_i.clear) begin
      len_d = '0;
      cnt_d = '0;
    end else if (cmd_i.insert) begin
      cnt_d = cnt_q + 1'b1;
      if (lo_q == len_q) len_d = len_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q <= len_d;
      cnt_q <= cnt_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.element   <= item_rd_q;
      out_q.position  <= PosW'(j_q);
      out_q.length    <= LenW'(len_q);
      out_q.final_res <= (j_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    status_o.in_last     = in_item_i.last;
    status_o.store_full  = (cnt_q == CntW'(MaxItems));
    status_o.search_done = search_done;
    status_o.run_last    = last_q;
    status_o.empty       = (len_q == '0);
    status_o.walk_done   = walk_done;
    status_o.out_stall   = out_valid_q & ~out_ready_i;
  end

endmodule

/* hdl/lis_ctrl.sv */
// Controller: sequences search, insert and the backward walk of each run.
module lis_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lis_pkg::status_t status_i,
  output lis_pkg::cmd_t    cmd_o
);
  import lis_pkg::*;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (!status_i.store_full) begin
            state_d = StSearch;
          end else if (status_i.in_last) begin
            // Drop the value but still rebuild over what is stored
            state_d = StTail;
          end
        end
      end
      StSearch: begin
        cmd_o.search = 1'b1;
        if (status_i.search_done) state_d = StInsert;
      end
      StInsert: begin
        cmd_o.insert = 1'b1;
        state_d = status_i.run_last ? StTail : StIdle;
      end
      StTail: begin
        cmd_o.tail_fetch = 1'b1;
        state_d = status_i.empty ? StClear : StInit;
      end
      StInit: begin
        cmd_o.walk_init = 1'b1;
        state_d = StWalk;
      end
      StWalk: begin
        // Hold while a result waits for its transfer
        if (!status_i.out_stall) begin
          cmd_o.walk = 1'b1;
          if (status_i.walk_done) state_d = StClear;
        end
      end
      StClear: begin
        cmd_o.clear = 1'b1;
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hdl/longest_increasing_subsequence_core.sv */
// Top level of the longest strictly increasing subsequence core.
// Each value is taken only in the idle state; a search over the tail table, one tail table read per
// bisection step over the current tails, and an insert follow before the next value can be taken.
// A value flagged last then starts a walk over the stored items from the newest back to the
// first element of the subsequence; the walk holds while a result is not taken. A value that
// meets a full store is dropped. Reset is asynchronous and clears the fill counts.
module longest_increasing_subsequence_core #(
  parameter int unsigned MaxItems = lis_pkg::MaxItemsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lis_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lis_pkg::out_item_t out_item_o
);
  import lis_pkg::*;

  cmd_t    cmd;
  status_t status;

  lis_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lis_datapath #(
    .MaxItems (MaxItems)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

/* hdl/lis_checker.sv */
// Port-level checker for the result stream of the subsequence core, with its bind.
module lis_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input lis_pkg::out_item_t out_item_o
);
  import lis_pkg::*;

  logic            xfer;
  logic            more_q;
  logic [PosW-1:0] pos_q;
  logic [LenW-1:0] len_q;

  assign xfer = out_valid_o & out_ready_i;

  // Track where the current run stands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      more_q <= 1'b0;
      pos_q  <= '0;
      len_q  <= '0;
    end else if (xfer) begin
      more_q <= ~out_item_o.final_res;
      pos_q  <= out_item_o.position;
      len_q  <= out_item_o.length;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  a_final_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.final_res == (out_item_o.position == '0)))
    else $error("end-of-run flag does not match position zero");

  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && !more_q |-> (out_item_o.length != '0) &&
      (out_item_o.position == PosW'(out_item_o.length - 1'b1)))
    else $error("run does not start at its last position");

  a_run_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && more_q |-> (out_item_o.position == pos_q - 1'b1) &&
      (out_item_o.length == len_q))
    else $error("positions of a run do not step down by one");

endmodule

bind longest_increasing_subsequence_core lis_checker u_lis_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
